[rtl/gtp_pkg.sv]
// shared types, constants and helpers for the tanh-form gelu pipeline
`timescale 1ns / 1ps
`default_nettype none

package gtp_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    localparam int SH_L = (FRAC_BITS <= 16) ? 16 - FRAC_BITS : 0;
    localparam int SH_R = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;

    localparam int UW = 20;
    localparam int PW = 40;
    localparam int RW = 41;
    localparam int QW = 17;
    localparam int TW = 19;
    localparam int DIV_STEPS = QW;
    localparam int LATENCY = 12 + DIV_STEPS;

    localparam logic signed [31:0] K_CUBE    = 32'sd2930;
    localparam logic signed [31:0] K_SQRT2PI = 32'sd52290;
    localparam logic signed [31:0] U_LIMIT   = 32'sd327680;
    localparam logic signed [TW-1:0] T_ONE   = 19'sd65536;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x_in;
        logic                         last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] y_out;
        logic                         last_out;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] xq;
        logic                         last;
    } meta_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/gelu_tanh_pade.sv]
// gelu activation, tanh form with pade[7/6] ratio, fully pipelined top level
//
// One Q4.12 activation per clock in, one result per clock out; done
// marks the result of each start pulse, busy is never raised and done
// cannot be held off. The pipeline is twelve arithmetic stages (input
// scaling, cubic term, polynomial products, ratio numerator and output
// multiply) plus seventeen stages of a restoring divider, one quotient bit
// per stage. Items are independent and last rides along with its value.
`timescale 1ns / 1ps
`default_nettype none

module gelu_tanh_pade
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire gtp_pkg::in_item_t  data,
    output logic                    done,
    output gtp_pkg::out_item_t      result
);

    localparam int DW = gtp_pkg::DATA_WIDTH;
    localparam int UW = gtp_pkg::UW;
    localparam int PW = gtp_pkg::PW;
    localparam int RW = gtp_pkg::RW;
    localparam int QW = gtp_pkg::QW;
    localparam int TW = gtp_pkg::TW;
    localparam int NS = gtp_pkg::DIV_STEPS;

    localparam logic signed [PW-1:0] C0 = 40'sd135135 <<< 16;

    logic [8:0]    v_reg;
    logic [NS+1:0] dv_reg;
    logic          out_v_reg;

    gtp_pkg::meta_t m_reg [1:9];
    gtp_pkg::meta_t dm_reg [0:NS];
    gtp_pkg::meta_t m28_reg;

    logic signed [31:0] x16_reg [1:3];
    logic signed [31:0] x2_reg;
    logic signed [31:0] x3_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] u_reg;
    logic               sat_reg [6:9];
    logic               pos_reg [6:9];
    logic signed [UW-1:0] uc_reg [6:9];
    logic signed [23:0] u2_reg [6:8];
    logic signed [27:0] u4_reg [7:8];
    logic signed [31:0] u6_reg;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] den9_reg;

    logic [RW-1:0] rem_reg [0:NS];
    logic [QW-1:0] q_reg [0:NS];
    logic [PW-1:0] den_reg [0:NS];
    logic          neg_reg [0:NS];
    logic          dsat_reg [0:NS];
    logic          dpos_reg [0:NS];
    logic          mag0_reg;

    logic signed [DW+TW-1:0] prod_reg;
    gtp_pkg::out_item_t      result_reg;

    logic signed [47:0]   xw_next;
    logic signed [31:0]   x16_next;
    logic signed [63:0]   p2_next;
    logic signed [63:0]   p3_next;
    logic signed [63:0]   pa_next;
    logic signed [31:0]   a3_next;
    logic signed [63:0]   sum_next;
    logic signed [63:0]   pu_next;
    logic                 sat_next;
    logic signed [UW-1:0] uc_next;
    logic signed [39:0]   pu2_next;
    logic signed [47:0]   pu4_next;
    logic signed [51:0]   pu6_next;
    logic signed [PW-1:0] pp_next;
    logic signed [PW-1:0] den_next;
    logic signed [59:0]   up_next;
    logic signed [43:0]   num_next;
    logic [43:0]          mag_next;
    logic signed [TW-1:0] t_next;
    logic signed [TW-1:0] opt_next;
    logic signed [DW+TW-1:0] prod_next;
    logic [RW-1:0]        trial_next [0:NS-1];
    logic                 fits_next [0:NS-1];

    assign busy = 1'b0;

    always_comb
    begin
        xw_next  = (48'(data.x_in) <<< gtp_pkg::SH_L) >>> gtp_pkg::SH_R;
        x16_next = gtp_pkg::sat32(64'(xw_next));
        p2_next  = 64'(x16_reg[1]) * 64'(x16_reg[1]);
        p3_next  = 64'(x2_reg) * 64'(x16_reg[2]);
        pa_next  = 64'(gtp_pkg::K_CUBE) * 64'(x3_reg);
        a3_next  = gtp_pkg::sat32(pa_next >>> 16);
        sum_next = 64'(x16_reg[3]) + 64'(a3_next);
        pu_next  = 64'(gtp_pkg::K_SQRT2PI) * 64'(s_reg);
        sat_next = (u_reg >= gtp_pkg::U_LIMIT) || (u_reg <= -gtp_pkg::U_LIMIT);
        uc_next  = sat_next ? '0 : u_reg[UW-1:0];
        pu2_next = 40'(uc_next) * 40'(uc_next);
        pu4_next = 48'(u2_reg[6]) * 48'(u2_reg[6]);
        pu6_next = 52'(u4_reg[7]) * 52'(u2_reg[7]);
        pp_next  = C0 + 40'sd17325 * PW'(u2_reg[8]) + 40'sd378 * PW'(u4_reg[8])
                   + PW'(u6_reg);
        den_next = C0 + 40'sd62370 * PW'(u2_reg[8]) + 40'sd3150 * PW'(u4_reg[8])
                   + 40'sd28 * PW'(u6_reg);
        up_next  = 60'(uc_reg[9]) * 60'(p_reg);
        num_next = up_next[59:16];
        mag_next = num_next[43] ? 44'(-num_next) : 44'(num_next);
        // restoring divider, one quotient bit per stage
        for (int k = 0; k < NS; k++)
        begin
            trial_next[k] = {rem_reg[k][RW-2:0], (k == 0) ? mag0_reg : 1'b0};
            fits_next[k]  = trial_next[k] >= RW'(den_reg[k]);
        end
        if (dsat_reg[NS])
            t_next = dpos_reg[NS] ? gtp_pkg::T_ONE : -gtp_pkg::T_ONE;
        else if (neg_reg[NS])
            t_next = -TW'(q_reg[NS]);
        else
            t_next = TW'(q_reg[NS]);
        opt_next  = gtp_pkg::T_ONE + t_next;
        prod_next = (DW+TW)'(dm_reg[NS].xq) * (DW+TW)'(opt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            dv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[7:0], start};
            dv_reg    <= {dv_reg[NS:0], v_reg[8]};
            out_v_reg <= dv_reg[NS+1];
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[1]     <= '{xq: data.x_in, last: data.last_in};
        for (int i = 2; i <= 9; i++)
            m_reg[i] <= m_reg[i-1];
        x16_reg[1]   <= x16_next;
        x16_reg[2]   <= x16_reg[1];
        x16_reg[3]   <= x16_reg[2];
        x2_reg       <= gtp_pkg::sat32(p2_next >>> 16);
        x3_reg       <= gtp_pkg::sat32(p3_next >>> 16);
        s_reg        <= gtp_pkg::sat32(sum_next);
        u_reg        <= gtp_pkg::sat32(pu_next >>> 16);
        sat_reg[6]   <= sat_next;
        pos_reg[6]   <= !u_reg[31];
        uc_reg[6]    <= uc_next;
        u2_reg[6]    <= 24'(pu2_next >>> 16);
        for (int i = 7; i <= 9; i++)
        begin
            sat_reg[i] <= sat_reg[i-1];
            pos_reg[i] <= pos_reg[i-1];
        end
        for (int i = 7; i <= 9; i++)
            uc_reg[i] <= uc_reg[i-1];
        u2_reg[7]    <= u2_reg[6];
        u2_reg[8]    <= u2_reg[7];
        u4_reg[7]    <= 28'(pu4_next >>> 16);
        u4_reg[8]    <= u4_reg[7];
        u6_reg       <= 32'(pu6_next >>> 16);
        p_reg        <= pp_next;
        den9_reg     <= den_next;
        rem_reg[0]   <= RW'(mag_next >> 1);
        mag0_reg     <= mag_next[0];
        q_reg[0]     <= '0;
        den_reg[0]   <= den9_reg;
        neg_reg[0]   <= num_next[43];
        dsat_reg[0]  <= sat_reg[9];
        dpos_reg[0]  <= pos_reg[9];
        dm_reg[0]    <= m_reg[9];
        for (int k = 0; k < NS; k++)
        begin
            rem_reg[k+1]  <= fits_next[k] ? trial_next[k] - RW'(den_reg[k])
                                          : trial_next[k];
            q_reg[k+1]    <= {q_reg[k][QW-2:0], fits_next[k]};
            den_reg[k+1]  <= den_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            dsat_reg[k+1] <= dsat_reg[k];
            dpos_reg[k+1] <= dpos_reg[k];
            dm_reg[k+1]   <= dm_reg[k];
        end
        prod_reg     <= prod_next;
        m28_reg      <= dm_reg[NS];
        result_reg.y_out    <= prod_reg[DW+16:17];
        result_reg.last_out <= m28_reg.last;
    end

    assign done   = out_v_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(gtp_pkg::LATENCY) done)
        else $error("item did not come out after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(gtp_pkg::LATENCY) !done)
        else $error("result strobe without an item");

    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !data.x_in[DW-1]) |-> ##(gtp_pkg::LATENCY) !result.y_out[DW-1])
        else $error("nonnegative input gave negative result");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(gtp_pkg::LATENCY)
            (result.last_out == $past(data.last_in, gtp_pkg::LATENCY)))
        else $error("last flag not carried with its item");

endmodule

`default_nettype wire
